// ===== design/sfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg
// shared constants, register map and pipeline control types for the stereo
// feedback delay core
// ----------------------------------------------------------------------------
package sfd_pkg;

  // default sizing
  localparam int SFD_LINE_DEPTH  = 131072;
  localparam int SFD_SAMPLE_BITS = 24;

  // register field widths
  localparam int DLY_W  = 17;
  localparam int GAIN_W = 16;

  // apb port
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  // q1.15 gain arithmetic
  localparam int Q_SHIFT  = 15;
  localparam int RND_HALF = 16384;

  // register reset values
  localparam logic [DLY_W-1:0]  DELAY_RST = 17'd24000;
  localparam logic [GAIN_W-1:0] FB_RST    = 16'd16384;
  localparam logic [GAIN_W-1:0] DRY_RST   = 16'd32768;
  localparam logic [GAIN_W-1:0] WET_RST   = 16'd16384;

  // register map, word index of paddr
  typedef enum logic [1:0] {
    REG_DELAY = 2'd0,
    REG_FB    = 2'd1,
    REG_DRY   = 2'd2,
    REG_WET   = 2'd3
  } reg_idx_t;

  // pipeline control handed from the top level to each channel
  typedef struct packed {
    logic accept;    // word taken into stage 1, delay line read issued
    logic s1_go;     // stage 1 moves on, delay line written
    logic s2_go;     // stage 2 moves into the output register
    logic fwd_self;  // zero delay: tap is the word just taken
    logic fwd_prev;  // tap is the slot written by the previous word
    logic filled;    // tap slot has been written since reset
  } sfd_ctl_t;

endpackage

// ===== design/sfd_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_in_if
// valid/ready channel carrying one stereo input word
// ----------------------------------------------------------------------------
interface sfd_in_if import sfd_pkg::*; #(
  parameter int W = SFD_SAMPLE_BITS
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] left_in;
  logic signed [W-1:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

// ===== design/sfd_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_out_if
// valid/ready channel carrying one stereo result word
// ----------------------------------------------------------------------------
interface sfd_out_if import sfd_pkg::*; #(
  parameter int W = SFD_SAMPLE_BITS
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] left_out;
  logic signed [W-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

// ===== design/sfd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_ram
// simple dual port ram, one write and one registered read per cycle,
// read returns the old data on a same address collision
// ----------------------------------------------------------------------------
module sfd_ram #(
  parameter  int WIDTH = 24,
  parameter  int DEPTH = 1024,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/sfd_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_cfg
// apb register file plus a two stage reduction of the delay register
// modulo the line depth
// ----------------------------------------------------------------------------
module sfd_cfg import sfd_pkg::*; #(
  parameter  int LINE_DEPTH = SFD_LINE_DEPTH,
  localparam int AW         = $clog2(LINE_DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic [AW-1:0]     delay_mod,
  output logic [GAIN_W-1:0] fb_gain,
  output logic [GAIN_W-1:0] dry_gain,
  output logic [GAIN_W-1:0] wet_gain,
  output logic              busy
);

  // reciprocal for d mod LINE_DEPTH: q estimate is exact or one low
  localparam int MOD_SH = DLY_W + AW;
  localparam int MUL_W  = DLY_W + 2;
  localparam int PRD_W  = DLY_W + MUL_W;
  localparam int MW     = ((AW > DLY_W) ? AW : DLY_W) + 1;
  localparam logic [MUL_W-1:0] MOD_MUL = MUL_W'((64'd1 << MOD_SH) / LINE_DEPTH);
  localparam logic [MW-1:0]    DEPTH_M = MW'(LINE_DEPTH);

  logic [DLY_W-1:0]  delay_r;
  logic [GAIN_W-1:0] fb_r;
  logic [GAIN_W-1:0] dry_r;
  logic [GAIN_W-1:0] wet_r;
  logic [1:0]        settle_r;
  logic [PRD_W-1:0]  prod_r;
  logic [AW-1:0]     mod_r;

  logic     wr_en;
  reg_idx_t idx;
  logic [MW-1:0] quot;
  logic [MW-1:0] qd;
  logic [MW-1:0] rem;
  logic [MW-1:0] rem_c;

  assign wr_en = psel & penable & pwrite;
  assign idx   = reg_idx_t'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r  <= DELAY_RST;
      fb_r     <= FB_RST;
      dry_r    <= DRY_RST;
      wet_r    <= WET_RST;
      settle_r <= 2'b11;
    end else begin
      settle_r <= settle_r >> 1;
      if (wr_en) begin
        unique case (idx)
          REG_DELAY: begin
            delay_r  <= pwdata[DLY_W-1:0];
            settle_r <= 2'b11;
          end
          REG_FB:  fb_r  <= pwdata[GAIN_W-1:0];
          REG_DRY: dry_r <= pwdata[GAIN_W-1:0];
          REG_WET: wet_r <= pwdata[GAIN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (idx)
      REG_DELAY: prdata = APB_DW'(delay_r);
      REG_FB:    prdata = APB_DW'(fb_r);
      REG_DRY:   prdata = APB_DW'(dry_r);
      REG_WET:   prdata = APB_DW'(wet_r);
      default:   prdata = '0;
    endcase
  end

  // remainder with one correction step
  assign quot  = MW'(prod_r >> MOD_SH);
  assign qd    = quot * DEPTH_M;
  assign rem   = MW'(delay_r) - qd;
  assign rem_c = (rem >= DEPTH_M) ? (rem - DEPTH_M) : rem;

  always_ff @(posedge clk) begin
    prod_r <= PRD_W'(delay_r) * PRD_W'(MOD_MUL);
    mod_r  <= rem_c[AW-1:0];
  end

  assign delay_mod = mod_r;
  assign fb_gain   = fb_r;
  assign dry_gain  = dry_r;
  assign wet_gain  = wet_r;
  assign busy      = |settle_r;

endmodule

// ===== design/sfd_chan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_chan
// one channel: delay line ram, feedback write-back and dry/wet mix
// ----------------------------------------------------------------------------
module sfd_chan import sfd_pkg::*; #(
  parameter  int LINE_DEPTH  = SFD_LINE_DEPTH,
  parameter  int SAMPLE_BITS = SFD_SAMPLE_BITS,
  localparam int AW          = $clog2(LINE_DEPTH),
  localparam int SB          = SAMPLE_BITS
) (
  input  logic                 clk,
  input  sfd_ctl_t             ctl,
  input  logic [AW-1:0]        rd_addr,
  input  logic [AW-1:0]        wr_addr,
  input  logic signed [SB-1:0] x_in,
  input  logic [GAIN_W-1:0]    fb_gain,
  input  logic [GAIN_W-1:0]    dry_gain,
  input  logic [GAIN_W-1:0]    wet_gain,
  output logic signed [SB-1:0] y_out
);

  localparam int PW = SB + GAIN_W + 1;   // sample times signed gain
  localparam int SW = SB + 3;            // rounded sum before saturation
  localparam logic signed [PW:0]   RND_P = (PW+1)'(RND_HALF);
  localparam logic signed [SW-1:0] SMAX  = {4'b0000, {(SB-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN  = {4'b1111, {(SB-1){1'b0}}};

  function automatic logic [SB-1:0] sat_s(input logic signed [SW-1:0] v);
    logic [SB-1:0] r;
    if (v > SMAX) begin
      r = SMAX[SB-1:0];
    end else if (v < SMIN) begin
      r = SMIN[SB-1:0];
    end else begin
      r = v[SB-1:0];
    end
    return r;
  endfunction

  logic signed [SB-1:0] x_r;
  logic signed [SB-1:0] fb_r;
  logic signed [PW-1:0] dry_p_r;
  logic signed [PW-1:0] wet_p_r;
  logic signed [SB-1:0] y_r;

  logic [SB-1:0]          ram_q;
  logic signed [SB-1:0]   delayed;
  logic signed [GAIN_W:0] fb_g;
  logic signed [GAIN_W:0] dry_g;
  logic signed [GAIN_W:0] wet_g;
  logic signed [PW-1:0]   fb_prod;
  logic signed [PW:0]     fb_bias;
  logic signed [PW:0]     fb_sh;
  logic signed [SW-1:0]   fb_sum;
  logic [SB-1:0]          fb_nxt;
  logic signed [PW:0]     mix_sum;
  logic signed [PW:0]     mix_sh;
  logic [SB-1:0]          y_nxt;

  sfd_ram #(
    .WIDTH (SB),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (ctl.s1_go),
    .waddr (wr_addr),
    .wdata (fb_nxt),
    .re    (ctl.accept),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  assign fb_g  = $signed({1'b0, fb_gain});
  assign dry_g = $signed({1'b0, dry_gain});
  assign wet_g = $signed({1'b0, wet_gain});

  // tap select: own input, last write-back still in flight, ram, or cleared slot
  always_comb begin
    if (ctl.fwd_self) begin
      delayed = x_r;
    end else if (ctl.fwd_prev) begin
      delayed = fb_r;
    end else if (ctl.filled) begin
      delayed = $signed(ram_q);
    end else begin
      delayed = '0;
    end
  end

  // feedback: x + round(delayed * fb), saturated
  assign fb_prod = delayed * fb_g;
  assign fb_bias = (PW+1)'(fb_prod) + RND_P;
  assign fb_sh   = fb_bias >>> Q_SHIFT;
  assign fb_sum  = SW'(x_r) + SW'(fb_sh);
  assign fb_nxt  = sat_s(fb_sum);

  // mix: round(dry * x + wet * delayed), saturated
  assign mix_sum = (PW+1)'(dry_p_r) + (PW+1)'(wet_p_r) + RND_P;
  assign mix_sh  = mix_sum >>> Q_SHIFT;
  assign y_nxt   = sat_s(mix_sh[SW-1:0]);

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      x_r <= x_in;
    end
    if (ctl.s1_go) begin
      fb_r    <= $signed(fb_nxt);
      dry_p_r <= x_r * dry_g;
      wet_p_r <= delayed * wet_g;
    end
    if (ctl.s2_go) begin
      y_r <= $signed(y_nxt);
    end
  end

  assign y_out = y_r;

endmodule

// ===== design/stereo_feedback_delay_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_feedback_delay_core
// stereo echo: two circular delay lines with feedback and a dry/wet mix
// ----------------------------------------------------------------------------
// The core takes one stereo word per clock unless the output stalls or the
// delay is being reduced, and returns one mixed stereo word per input word,
// valid on the port once it has passed the input register, product register
// and output register. The sustained rate is one word per cycle; it is set
// by the stage 1 feedback loop, where the delay line read data passes the tap
// select, one sample by gain multiply, the rounding add and saturation and is
// forwarded to the next word when the echo delay is one sample. Each
// channel's delay line is one simple dual port ram of LINE_DEPTH words, read
// once and written once per word. The lines read as zero after reset without
// a clearing pass: the write pointer only counts up, so a slot is treated as
// written once the pointer has passed it or has wrapped. After reset and
// after every write of the delay register the input stalls while the delay
// is reduced modulo LINE_DEPTH. Registers are written through the apb port,
// which never waits; write them only while no words are in flight.
// ----------------------------------------------------------------------------
module stereo_feedback_delay_core import sfd_pkg::*; #(
  parameter int LINE_DEPTH  = SFD_LINE_DEPTH,
  parameter int SAMPLE_BITS = SFD_SAMPLE_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  sfd_in_if.sink            in_port,
  sfd_out_if.source         out_port,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(LINE_DEPTH - 1);
  localparam logic [AW:0]   DEPTH_X  = (AW+1)'(LINE_DEPTH);

  // settings from the register file
  logic [AW-1:0]     delay_mod;
  logic [GAIN_W-1:0] fb_gain;
  logic [GAIN_W-1:0] dry_gain;
  logic [GAIN_W-1:0] wet_gain;
  logic              busy;

  // pipeline occupancy
  logic s1_v_r;
  logic s2_v_r;
  logic s3_v_r;

  // write pointer and fill tracking
  logic [AW-1:0] wi_r;
  logic [AW-1:0] wi_s1_r;
  logic          wrapped_r;

  // tap flags for the word in stage 1
  logic fwd_self_r;
  logic fwd_prev_r;
  logic filled_r;

  logic s3_free;
  logic s2_free;
  logic s1_free;
  logic s2_go;
  logic s1_go;
  logic in_ready;
  logic accept;

  logic [AW:0]   rd_full;
  logic [AW-1:0] rd_addr;
  sfd_ctl_t      ctl;

  assign pready = 1'b1;

  sfd_cfg #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .delay_mod (delay_mod),
    .fb_gain   (fb_gain),
    .dry_gain  (dry_gain),
    .wet_gain  (wet_gain),
    .busy      (busy)
  );

  // handshake chain: each stage moves when the next one is free or draining
  assign s3_free  = !s3_v_r || out_port.ready;
  assign s2_go    = s2_v_r && s3_free;
  assign s2_free  = !s2_v_r || s3_free;
  assign s1_go    = s1_v_r && s2_free;
  assign s1_free  = !s1_v_r || s2_free;
  assign in_ready = s1_free && !busy;
  assign accept   = in_port.valid && in_ready;

  assign in_port.ready = in_ready;
  assign out_port.valid = s3_v_r;

  // tap address: write pointer minus delay, wrapped into the line
  always_comb begin
    if (wi_r >= delay_mod) begin
      rd_full = {1'b0, wi_r} - {1'b0, delay_mod};
    end else begin
      rd_full = {1'b0, wi_r} + DEPTH_X - {1'b0, delay_mod};
    end
  end
  assign rd_addr = rd_full[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      s3_v_r    <= 1'b0;
      wi_r      <= '0;
      wrapped_r <= 1'b0;
    end else begin
      s1_v_r <= accept || (s1_v_r && !s1_go);
      s2_v_r <= s1_go || (s2_v_r && !s2_go);
      s3_v_r <= s2_go || (s3_v_r && !out_port.ready);
      if (accept) begin
        if (wi_r == LAST_IDX) begin
          wi_r      <= '0;
          wrapped_r <= 1'b1;
        end else begin
          wi_r <= wi_r + 1'b1;
        end
      end
    end
  end

  // stage 1 bookkeeping, captured with the word
  always_ff @(posedge clk) begin
    if (accept) begin
      wi_s1_r    <= wi_r;
      fwd_self_r <= (delay_mod == '0);
      // the word now leaving stage 1 writes its slot on this same edge
      fwd_prev_r <= s1_v_r && (rd_addr == wi_s1_r);
      filled_r   <= wrapped_r || (rd_addr < wi_r);
    end
  end

  assign ctl.accept   = accept;
  assign ctl.s1_go    = s1_go;
  assign ctl.s2_go    = s2_go;
  assign ctl.fwd_self = fwd_self_r;
  assign ctl.fwd_prev = fwd_prev_r;
  assign ctl.filled   = filled_r;

  sfd_chan #(
    .LINE_DEPTH  (LINE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_left (
    .clk      (clk),
    .ctl      (ctl),
    .rd_addr  (rd_addr),
    .wr_addr  (wi_s1_r),
    .x_in     (in_port.left_in),
    .fb_gain  (fb_gain),
    .dry_gain (dry_gain),
    .wet_gain (wet_gain),
    .y_out    (out_port.left_out)
  );

  sfd_chan #(
    .LINE_DEPTH  (LINE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_right (
    .clk      (clk),
    .ctl      (ctl),
    .rd_addr  (rd_addr),
    .wr_addr  (wi_s1_r),
    .x_in     (in_port.right_in),
    .fb_gain  (fb_gain),
    .dry_gain (dry_gain),
    .wet_gain (wet_gain),
    .y_out    (out_port.right_out)
  );

`ifndef NO_ASSERTIONS
  // write pointer steps by one per word and wraps at the line end
  a_wi_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (wi_r == (($past(wi_r) == LAST_IDX) ? '0 : $past(wi_r) + 1'b1)))
    else $error("write pointer did not advance by one");

  // pointer never leaves the line
  a_wi_range: assert property (@(posedge clk) disable iff (!rst_n)
    wi_r <= LAST_IDX)
    else $error("write pointer beyond line depth");

  // once every slot has been written it stays that way
  a_wrap_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    wrapped_r |=> wrapped_r)
    else $error("fill flag dropped");

  // a word in stage 1 never forwards both its own input and the previous write
  a_fwd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> !(fwd_self_r && fwd_prev_r))
    else $error("conflicting tap forwarding");

  // a word leaving stage 2 shows up at the output on the next cycle
  a_s2_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s2_go |=> s3_v_r)
    else $error("result lost between stage 2 and output");
`endif

endmodule

// ===== tb/stereo_feedback_delay_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_feedback_delay_checker
// watches the sample, result and register ports of the echo core, keeps its
// own copy of both delay lines and the registers, and compares every result
// word with the mix it predicts
// ----------------------------------------------------------------------------
module stereo_feedback_delay_checker import sfd_pkg::*; (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic signed [SFD_SAMPLE_BITS-1:0] in_left,
  input  logic signed [SFD_SAMPLE_BITS-1:0] in_right,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [SFD_SAMPLE_BITS-1:0] out_left,
  input  logic signed [SFD_SAMPLE_BITS-1:0] out_right,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic                              cfg_pready,
  input  logic [APB_AW-1:0]                 cfg_paddr,
  input  logic [APB_DW-1:0]                 cfg_pwdata,
  output int                                mismatch_count,
  output int                                words_pending
);

  localparam int DEPTH = SFD_LINE_DEPTH;
  localparam int SB    = SFD_SAMPLE_BITS;
  localparam longint SMAX = (longint'(1) <<< (SB - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;

  typedef logic signed [SB-1:0] sample_t;
  typedef struct packed {
    sample_t left;
    sample_t right;
  } stereo_t;

  sample_t           left_echo  [DEPTH];
  sample_t           right_echo [DEPTH];
  int unsigned       wr_ptr;
  logic [DLY_W-1:0]  echo_delay;
  logic [GAIN_W-1:0] fb_gain;
  logic [GAIN_W-1:0] dry_mix;
  logic [GAIN_W-1:0] wet_mix;
  stereo_t           mixed_q[$];
  int                errs = 0;

  function automatic sample_t clip(input longint v);
    if (v > SMAX) return sample_t'(SMAX);
    if (v < SMIN) return sample_t'(SMIN);
    return sample_t'(v);
  endfunction

  // add half then floor shift
  function automatic longint round_q15(input longint v);
    return (v + RND_HALF) >>> Q_SHIFT;
  endfunction

  function automatic void echo_step(input sample_t x, input sample_t tap,
                                    output sample_t stored, output sample_t mixed);
    stored = clip(longint'(x) + round_q15(longint'(tap) * longint'(fb_gain)));
    mixed  = clip(round_q15(longint'(dry_mix) * longint'(x) +
                            longint'(wet_mix) * longint'(tap)));
  endfunction

  always @(posedge clk) begin
    int unsigned d;
    int unsigned rd;
    sample_t     tap_l, tap_r, keep_l, keep_r, mix_l, mix_r;
    stereo_t     want;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        left_echo[i]  = '0;
        right_echo[i] = '0;
      end
      wr_ptr     = 0;
      echo_delay = DELAY_RST;
      fb_gain    = FB_RST;
      dry_mix    = DRY_RST;
      wet_mix    = WET_RST;
      mixed_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (mixed_q.size() == 0) begin
          errs++;
          $display("%0t unexpected word: expected none, actual left %0d right %0d",
                   $time, out_left, out_right);
        end else begin
          want = mixed_q.pop_front();
          if (want.left != out_left) begin
            errs++;
            $display("%0t left_out: expected %0d, actual %0d",
                     $time, $signed(want.left), out_left);
          end
          if (want.right != out_right) begin
            errs++;
            $display("%0t right_out: expected %0d, actual %0d",
                     $time, $signed(want.right), out_right);
          end
        end
      end

      if (in_valid && in_ready) begin
        d  = echo_delay % DEPTH;
        rd = (wr_ptr >= d) ? wr_ptr - d : wr_ptr + DEPTH - d;
        // zero delay taps the word being written
        tap_l = (d == 0) ? in_left  : left_echo[rd];
        tap_r = (d == 0) ? in_right : right_echo[rd];
        echo_step(in_left, tap_l, keep_l, mix_l);
        echo_step(in_right, tap_r, keep_r, mix_r);
        left_echo[wr_ptr]  = keep_l;
        right_echo[wr_ptr] = keep_r;
        wr_ptr = (wr_ptr + 1 == DEPTH) ? 0 : wr_ptr + 1;
        mixed_q.push_back('{left: mix_l, right: mix_r});
      end

      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[APB_AW-1:2]))
          REG_DELAY: echo_delay = cfg_pwdata[DLY_W-1:0];
          REG_FB:    fb_gain    = cfg_pwdata[GAIN_W-1:0];
          REG_DRY:   dry_mix    = cfg_pwdata[GAIN_W-1:0];
          REG_WET:   wet_mix    = cfg_pwdata[GAIN_W-1:0];
          default: ;
        endcase
      end
    end
    words_pending  <= mixed_q.size();
    mismatch_count <= errs;
  end

endmodule

// ===== tb/stereo_feedback_delay_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_feedback_delay_core_test
// drives stereo sample words and register writes into the echo core with
// random gaps and output stalls, while a checker beside the core predicts
// every mixed word; a short directed pass covers extremes, zero and one
// sample delays, gains above unity and the longest delay, then random
// register settings follow with random sample streams
// ----------------------------------------------------------------------------
module stereo_feedback_delay_core_test;
  import sfd_pkg::*;

  localparam int SB = SFD_SAMPLE_BITS;
  // longest stretch with nothing accepted before the run is called hung
  localparam int HANG_LIMIT = 2000;
  localparam int RANDOM_WORDS = 950;

  localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic [GAIN_W-1:0]    UNITY      = 16'd32768;
  localparam logic [GAIN_W-1:0]    GAIN_TOP   = {GAIN_W{1'b1}};
  localparam logic [DLY_W-1:0]     DELAY_TOP  = {DLY_W{1'b1}};

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // register port
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [APB_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  int   mismatches;
  int   words_pending;
  int   words_sent = 0;
  int   stall_cycles = 0;
  logic calm = 1'b0;  // no idling on either side while set

  sfd_in_if  in_ch();
  sfd_out_if out_ch();

  stereo_feedback_delay_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_port  (in_ch),
    .out_port (out_ch),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .pready   (cfg_pready)
  );

  stereo_feedback_delay_checker echo_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_left        (in_ch.left_in),
    .in_right       (in_ch.right_in),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_left       (out_ch.left_out),
    .out_right      (out_ch.right_out),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_pready     (cfg_pready),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .mismatch_count (mismatches),
    .words_pending  (words_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side stalls about a third of the cycles
  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(0, 99) >= 33);
  end

  // watchdog: any word taken or delivered, or any register access, restarts the count
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_psel && cfg_penable)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= HANG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // one apb write, setup then access; upper bits beyond the field get junk
  // now and then, the core must drop them
  task automatic cfg_write(input reg_idx_t idx, input logic [APB_DW-1:0] value);
    int                fw;
    logic [APB_DW-1:0] junk;
    fw   = (idx == REG_DELAY) ? DLY_W : GAIN_W;
    junk = ($urandom_range(0, 3) == 0) ? ($urandom() << fw) : '0;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= junk | (value & ((32'd1 << fw) - 1));
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering words, then wait for the checker to see every expected word
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // registers only change with the core empty
  task automatic set_echo(input logic [DLY_W-1:0] dly, input logic [GAIN_W-1:0] fb,
                          input logic [GAIN_W-1:0] dry, input logic [GAIN_W-1:0] wet);
    wait_drained();
    cfg_write(REG_DELAY, APB_DW'(dly));
    cfg_write(REG_FB, APB_DW'(fb));
    cfg_write(REG_DRY, APB_DW'(dry));
    cfg_write(REG_WET, APB_DW'(wet));
  endtask

  // offer one stereo word; valid stays up into the next word when no gap
  task automatic send_word(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r);
    while (!calm && $urandom_range(0, 99) < 33) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.left_in  <= l;
    in_ch.right_in <= r;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  function automatic logic signed [SB-1:0] pick_sample();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 7))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2, 3:    return {{(SB-9){r[8]}}, r[8:0]};   // quiet signal
      default: return r[SB-1:0];
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return UNITY;
      2:       return GAIN_TOP;
      3:       return GAIN_W'($urandom_range(0, 65535));   // above unity too
      default: return GAIN_W'($urandom_range(0, 32768));
    endcase
  endfunction

  initial begin
    int               phase_len;
    int               phase_no;
    logic [DLY_W-1:0] dly;
    cfg_psel       <= 1'b0;
    cfg_penable    <= 1'b0;
    cfg_pwrite     <= 1'b0;
    cfg_paddr      <= '0;
    cfg_pwdata     <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.left_in  <= '0;
    in_ch.right_in <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, long delay so the tap still reads cleared slots
    send_word(SAMPLE_MAX, SAMPLE_MIN);
    send_word(SAMPLE_MIN, SAMPLE_MAX);
    send_word('0, '0);
    send_word(-24'sd1, 24'sd1);
    send_word(pick_sample(), pick_sample());

    // zero delay: the wet path hears the input itself and the sums clip
    set_echo('0, UNITY, UNITY, UNITY);
    send_word(SAMPLE_MAX, SAMPLE_MIN);
    send_word(24'sh400000, -24'sh400000);
    send_word(24'sd1, -24'sd1);
    send_word('0, '0);

    // one sample delay, every gain above unity
    set_echo(17'd1, GAIN_TOP, GAIN_TOP, GAIN_TOP);
    send_word(SAMPLE_MAX, SAMPLE_MIN);
    send_word(SAMPLE_MAX, SAMPLE_MIN);
    send_word(24'sh123456, -24'sh123456);
    send_word(SAMPLE_MIN, SAMPLE_MAX);
    send_word('0, '0);

    // all gains off
    set_echo(17'd2, '0, '0, '0);
    send_word(SAMPLE_MAX, SAMPLE_MIN);
    send_word(SAMPLE_MIN, SAMPLE_MAX);
    send_word(pick_sample(), pick_sample());

    // longest delay taps the slot after the pointer, not yet written
    set_echo(DELAY_TOP, UNITY, '0, UNITY);
    send_word(SAMPLE_MAX, SAMPLE_MIN);
    send_word(SAMPLE_MIN, SAMPLE_MAX);
    send_word(pick_sample(), pick_sample());

    // random settings, each followed by a random stream
    phase_no = 0;
    while (words_sent < RANDOM_WORDS + 20) begin
      case ($urandom_range(0, 9))
        0:       dly = '0;
        1:       dly = 17'd1;
        2:       dly = 17'd2;
        3:       dly = DELAY_TOP;
        4:       dly = DLY_W'($urandom_range(0, 131071));
        5:       dly = DLY_W'($urandom_range(32, 200));
        default: dly = DLY_W'($urandom_range(0, 40));
      endcase
      set_echo(dly, pick_gain(), pick_gain(), pick_gain());
      calm      = (phase_no == 3);
      phase_len = $urandom_range(30, 120);
      repeat (phase_len) send_word(pick_sample(), pick_sample());
      calm = 1'b0;
      phase_no++;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
